// ===== hdl/tlbdp_pkg.sv =====
`timescale 1ns / 1ps

package tlbdp_pkg;

	localparam int PAGE_W  = 8;
	localparam int FRAME_W = 10;
	localparam int CFG_W   = 10;
	localparam int FAULT_W = 16;
	localparam int STAMP_W = 32;

	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	typedef enum logic [2:0] {
		ST_TLB_HIT      = 3'd0,
		ST_TABLE_HIT    = 3'd1,
		ST_FAULT_FREE   = 3'd2,
		ST_FAULT_EVICT  = 3'd3,
		ST_NO_FRAMES    = 3'd4,
		ST_OUT_OF_RANGE = 3'd5
	} status_t;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_BASE_FRAME  = 2'd0;
	localparam cfg_idx_t REG_FRAME_COUNT = 2'd1;
	localparam cfg_idx_t REG_TLB_USED    = 2'd2;
	localparam cfg_idx_t REG_PAGE_COUNT  = 2'd3;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              new_run;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  evicted_page;
		logic [FAULT_W-1:0] fault_count;
	} rsp_t;

endpackage

// ===== hdl/tlbdp_stream_if.sv =====
`timescale 1ns / 1ps

interface tlbdp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/tlbdp_ram.sv =====
`timescale 1ns / 1ps

module tlbdp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/tlbdp_tlb.sv =====
`timescale 1ns / 1ps

module tlbdp_tlb #(
	parameter int TLB_DEPTH = 16,
	localparam int TI_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1,
	localparam int LIM_W = ($clog2(TLB_DEPTH + 1) > 5) ? $clog2(TLB_DEPTH + 1) : 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clr,
	input  logic                         we,
	input  logic [TI_W-1:0]              widx,
	input  logic [tlbdp_pkg::PAGE_W-1:0]  wpage,
	input  logic [tlbdp_pkg::FRAME_W-1:0] wframe,
	input  logic                         inv,
	input  logic [tlbdp_pkg::PAGE_W-1:0]  inv_page,
	input  logic [tlbdp_pkg::PAGE_W-1:0]  look_page,
	output logic                         hit,
	output logic [tlbdp_pkg::FRAME_W-1:0] hit_frame,
	input  logic [LIM_W-1:0]             limit,
	output logic                         full,
	output logic [TI_W-1:0]              free_idx,
	input  logic [TI_W-1:0]              rd_idx,
	output logic [tlbdp_pkg::PAGE_W-1:0]  rd_page,
	output logic                         rd_valid
);

	logic [TLB_DEPTH-1:0]            valid_q;
	logic [tlbdp_pkg::PAGE_W-1:0]  page_q  [TLB_DEPTH];
	logic [tlbdp_pkg::FRAME_W-1:0] frame_q [TLB_DEPTH];
	logic [LIM_W-1:0]              used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < TLB_DEPTH; i++) begin
				if (inv && valid_q[i] && page_q[i] == inv_page) begin
					valid_q[i] <= 1'b0;
				end
			end
			if (we) begin
				valid_q[widx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			page_q[widx]  <= wpage;
			frame_q[widx] <= wframe;
		end
	end

	// lowest matching slot wins, lowest empty slot is filled first
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		free_idx  = '0;
		used      = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == look_page) begin
				hit       = 1'b1;
				hit_frame = frame_q[i];
			end
			if (!valid_q[i]) begin
				free_idx = TI_W'(i);
			end
			used = used + LIM_W'(valid_q[i]);
		end
	end

	assign full     = (used >= limit);
	assign rd_page  = page_q[rd_idx];
	assign rd_valid = valid_q[rd_idx];

endmodule

// ===== hdl/tlb_lru_demand_paging.sv =====
`timescale 1ns / 1ps

// Demand-paging translator: one page request in on req, one result out on rsp.
// Both channels use valid/ready; a request is taken when both are high.
// Configuration (base frame, frame count, TLB entries in use, page count) is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// no request is in flight, as the block itself does not enforce this. Stamps
// and page frames live in two single-read-port RAMs; the TLB is flops.
// Toward the result register: a TLB hit, out-of-range or no-frames request
// goes straight to it; a table hit puts the page in the TLB; a free-frame
// fault first reduces the frame number modulo PHYS_FRAMES if it wraps, then
// inserts it. A full TLB finds its LRU entry by sweeping the stamp RAM.
// A fault with eviction first sweeps the stamp RAM over all MAX_PAGES pages.
// One request is processed at a time; the next can be taken in the cycle
// after the result is written, while that result may still wait in the
// output register. If rsp stalls, processing stops before the result is
// written and req stays not ready. Reset clears the tables' valid bits and
// counters and sets the configuration to base 0, 0 frames, 16 TLB entries
// and 256 pages; a request with new_run clears the run state before lookup.
module tlb_lru_demand_paging #(
	parameter int MAX_PAGES   = 256,
	parameter int MAX_FRAMES  = 64,
	parameter int TLB_DEPTH   = 16,
	parameter int PHYS_FRAMES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  tlbdp_pkg::cfg_idx_t        cfg_index,
	input  logic [tlbdp_pkg::CFG_W-1:0] cfg_data,
	tlbdp_stream_if.sink               req,
	tlbdp_stream_if.source             rsp
);

	localparam int PG_W  = $clog2(MAX_PAGES);
	localparam int PC_W  = PG_W + 1;
	localparam int TI_W  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int TC_W  = $clog2(TLB_DEPTH + 1);
	localparam int LIM_W = ($clog2(TLB_DEPTH + 1) > 5) ? $clog2(TLB_DEPTH + 1) : 5;
	localparam int FC_W  = ($clog2(MAX_FRAMES + 1) > 7) ? $clog2(MAX_FRAMES + 1) : 7;
	localparam int SUM_W = ($clog2(PHYS_FRAMES + 1) > 12) ? $clog2(PHYS_FRAMES + 1) : 12;
	localparam int PW    = tlbdp_pkg::PAGE_W;
	localparam int FW    = tlbdp_pkg::FRAME_W;
	localparam int SW    = tlbdp_pkg::STAMP_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CLASS, S_MOD, S_EVSCAN, S_EVFRAME, S_EVAPPLY,
		S_INS, S_TSCAN, S_TWRITE, S_FINISH, S_OUT
	} state_t;

	state_t state_q;

	logic [9:0] base_q;
	logic [6:0] fcnt_q;
	logic [4:0] tlbn_q;
	logic [8:0] pcnt_q;

	logic [PW-1:0]              pg_q;
	logic [FW-1:0]              fr_q;
	logic [PW-1:0]              ev_q;
	tlbdp_pkg::status_t         status_q;
	logic [MAX_PAGES-1:0]       page_valid_q;
	logic [FC_W-1:0]            fho_q;
	logic [SW-1:0]              ref_q;
	logic [tlbdp_pkg::FAULT_W-1:0] faults_q;
	logic [SUM_W-1:0]           sum_q;
	logic [PC_W-1:0]            scan_q;
	logic [TC_W-1:0]            tscan_q;

	logic            s1_vld;
	logic [PG_W-1:0] s1_page;
	logic [TI_W-1:0] s1_slot;
	logic            found_q;
	logic [SW-1:0]   best_stamp_q;
	logic [PG_W-1:0] best_page_q;
	logic [TI_W-1:0] best_slot_q;

	logic               out_vld_q;
	tlbdp_pkg::rsp_t    out_q;

	logic            accept;
	logic [PG_W-1:0] pa;
	logic            oor;
	logic [FC_W-1:0] frames;
	logic [LIM_W-1:0] tlb_lim;
	logic            counted;
	logic            better;
	logic            mod_over;

	logic            lu_re, lu_we;
	logic [PG_W-1:0] lu_raddr;
	logic [SW-1:0]   lu_rdata;
	logic            pf_re, pf_we;
	logic [PG_W-1:0] pf_raddr;
	logic [FW-1:0]   pf_wdata, pf_rdata;

	logic            tlb_clr, tlb_we, tlb_hit, tlb_full, tlb_rd_valid;
	logic [TI_W-1:0] tlb_widx, tlb_free_idx;
	logic [FW-1:0]   tlb_hit_frame;
	logic [PW-1:0]   tlb_rd_page;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign pa       = PG_W'(pg_q);
	assign oor      = ({1'b0, pg_q} >= pcnt_q) || (32'(pg_q) >= MAX_PAGES);
	assign frames   = (FC_W'(fcnt_q) > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : FC_W'(fcnt_q);
	assign mod_over = (sum_q >= SUM_W'(PHYS_FRAMES));
	assign counted  = (status_q != tlbdp_pkg::ST_NO_FRAMES) &&
	                  (status_q != tlbdp_pkg::ST_OUT_OF_RANGE);

	always_comb begin
		tlb_lim = LIM_W'(tlbn_q);
		if (tlb_lim == '0) begin
			tlb_lim = LIM_W'(1);
		end
		if (tlb_lim > LIM_W'(TLB_DEPTH)) begin
			tlb_lim = LIM_W'(TLB_DEPTH);
		end
	end

	// older stamp wins; equal stamps go to the lower page
	assign better = !found_q || (lu_rdata < best_stamp_q) ||
	                (lu_rdata == best_stamp_q && s1_page < best_page_q);

	// stamp RAM: swept for the eviction victim or the TLB's LRU entry
	assign lu_re    = (state_q == S_TSCAN && tscan_q != TC_W'(TLB_DEPTH)) ||
	                  (state_q == S_EVSCAN && scan_q != PC_W'(MAX_PAGES));
	assign lu_raddr = (state_q == S_TSCAN) ? PG_W'(tlb_rd_page) : scan_q[PG_W-1:0];
	assign lu_we    = (state_q == S_FINISH) && counted;

	assign pf_re    = accept || (state_q == S_EVFRAME);
	assign pf_raddr = (state_q == S_EVFRAME) ? best_page_q : PG_W'(req.data.page);
	assign pf_we    = (state_q == S_MOD && !mod_over) || (state_q == S_EVAPPLY);
	assign pf_wdata = (state_q == S_EVAPPLY) ? pf_rdata : sum_q[FW-1:0];

	assign tlb_clr  = accept && req.data.new_run;
	assign tlb_we   = (state_q == S_INS && !tlb_full) || (state_q == S_TWRITE);
	assign tlb_widx = (state_q == S_TWRITE) ? best_slot_q : tlb_free_idx;

	tlbdp_ram #(.DEPTH(MAX_PAGES), .WIDTH(SW)) u_stamp_ram (
		.clk   (clk),
		.we    (lu_we),
		.waddr (pa),
		.wdata (ref_q),
		.re    (lu_re),
		.raddr (lu_raddr),
		.rdata (lu_rdata)
	);

	tlbdp_ram #(.DEPTH(MAX_PAGES), .WIDTH(FW)) u_frame_ram (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pa),
		.wdata (pf_wdata),
		.re    (pf_re),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	tlbdp_tlb #(.TLB_DEPTH(TLB_DEPTH)) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (tlb_clr),
		.we        (tlb_we),
		.widx      (tlb_widx),
		.wpage     (pg_q),
		.wframe    (fr_q),
		.inv       (state_q == S_EVAPPLY),
		.inv_page  (PW'(best_page_q)),
		.look_page (pg_q),
		.hit       (tlb_hit),
		.hit_frame (tlb_hit_frame),
		.limit     (tlb_lim),
		.full      (tlb_full),
		.free_idx  (tlb_free_idx),
		.rd_idx    (tscan_q[TI_W-1:0]),
		.rd_page   (tlb_rd_page),
		.rd_valid  (tlb_rd_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			fcnt_q       <= '0;
			tlbn_q       <= 5'd16;
			pcnt_q       <= 9'd256;
			pg_q         <= '0;
			fr_q         <= '0;
			ev_q         <= '0;
			status_q     <= tlbdp_pkg::ST_TLB_HIT;
			page_valid_q <= '0;
			fho_q        <= '0;
			ref_q        <= '0;
			faults_q     <= '0;
			sum_q        <= '0;
			scan_q       <= '0;
			tscan_q      <= '0;
			s1_vld       <= 1'b0;
			s1_page      <= '0;
			s1_slot      <= '0;
			found_q      <= 1'b0;
			best_stamp_q <= '0;
			best_page_q  <= '0;
			best_slot_q  <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tlbdp_pkg::REG_BASE_FRAME:  base_q <= cfg_data[9:0];
					tlbdp_pkg::REG_FRAME_COUNT: fcnt_q <= cfg_data[6:0];
					tlbdp_pkg::REG_TLB_USED:    tlbn_q <= cfg_data[4:0];
					tlbdp_pkg::REG_PAGE_COUNT:  pcnt_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			if (s1_vld && better) begin
				found_q      <= 1'b1;
				best_stamp_q <= lu_rdata;
				best_page_q  <= s1_page;
				best_slot_q  <= s1_slot;
			end
			s1_vld <= 1'b0;

			if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						pg_q <= req.data.page;
						fr_q <= '0;
						ev_q <= '0;
						if (req.data.new_run) begin
							page_valid_q <= '0;
							fho_q        <= '0;
							ref_q        <= '0;
							faults_q     <= '0;
						end
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (oor) begin
						status_q <= tlbdp_pkg::ST_OUT_OF_RANGE;
						state_q  <= S_FINISH;
					end else if (frames == '0) begin
						status_q <= tlbdp_pkg::ST_NO_FRAMES;
						state_q  <= S_FINISH;
					end else if (tlb_hit) begin
						status_q <= tlbdp_pkg::ST_TLB_HIT;
						fr_q     <= tlb_hit_frame;
						state_q  <= S_FINISH;
					end else if (page_valid_q[pa]) begin
						status_q <= tlbdp_pkg::ST_TABLE_HIT;
						fr_q     <= pf_rdata;
						state_q  <= S_INS;
					end else if (fho_q < frames) begin
						status_q <= tlbdp_pkg::ST_FAULT_FREE;
						sum_q    <= SUM_W'(base_q) + SUM_W'(fho_q);
						state_q  <= S_MOD;
					end else begin
						found_q <= 1'b0;
						scan_q  <= '0;
						state_q <= S_EVSCAN;
					end
				end
				S_MOD: begin
					// reduce modulo PHYS_FRAMES one subtract at a time
					if (mod_over) begin
						sum_q <= sum_q - SUM_W'(PHYS_FRAMES);
					end else begin
						fr_q             <= sum_q[FW-1:0];
						page_valid_q[pa] <= 1'b1;
						fho_q            <= fho_q + FC_W'(1);
						state_q          <= S_INS;
					end
				end
				S_EVSCAN: begin
					if (scan_q == PC_W'(MAX_PAGES)) begin
						state_q <= S_EVFRAME;
					end else begin
						s1_vld  <= page_valid_q[scan_q[PG_W-1:0]];
						s1_page <= scan_q[PG_W-1:0];
						s1_slot <= '0;
						scan_q  <= scan_q + PC_W'(1);
					end
				end
				S_EVFRAME: begin
					if (!found_q) begin
						status_q <= tlbdp_pkg::ST_NO_FRAMES;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_EVAPPLY;
					end
				end
				S_EVAPPLY: begin
					status_q                  <= tlbdp_pkg::ST_FAULT_EVICT;
					fr_q                      <= pf_rdata;
					ev_q                      <= PW'(best_page_q);
					page_valid_q[best_page_q] <= 1'b0;
					page_valid_q[pa]          <= 1'b1;
					state_q                   <= S_INS;
				end
				S_INS: begin
					if (tlb_full) begin
						found_q <= 1'b0;
						tscan_q <= '0;
						state_q <= S_TSCAN;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_TSCAN: begin
					if (tscan_q == TC_W'(TLB_DEPTH)) begin
						state_q <= S_TWRITE;
					end else begin
						s1_vld  <= tlb_rd_valid;
						s1_page <= PG_W'(tlb_rd_page);
						s1_slot <= tscan_q[TI_W-1:0];
						tscan_q <= tscan_q + TC_W'(1);
					end
				end
				S_TWRITE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (counted) begin
						ref_q <= ref_q + SW'(1);
						if ((status_q == tlbdp_pkg::ST_FAULT_FREE ||
						     status_q == tlbdp_pkg::ST_FAULT_EVICT) &&
						    faults_q != tlbdp_pkg::FAULT_MAX) begin
							faults_q <= faults_q + tlbdp_pkg::FAULT_W'(1);
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_vld_q || rsp.ready) begin
						out_q.status       <= status_q;
						out_q.frame        <= fr_q;
						out_q.evicted_page <= ev_q;
						out_q.fault_count  <= faults_q;
						out_vld_q          <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_tlb_lru_demand_paging.sv =====
`timescale 1ns / 1ps

module tb_tlb_lru_demand_paging;
	import tlbdp_pkg::*;

	localparam int N_PAGES  = 256;
	localparam int N_FRAMES = 64;
	localparam int N_TLB    = 16;
	localparam int N_PHYS   = 1024;
	localparam longint CYCLE_LIMIT = 3_000_000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	tlbdp_stream_if #(.T(req_t)) req_ch ();
	tlbdp_stream_if #(.T(rsp_t)) rsp_ch ();

	tlb_lru_demand_paging dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req(req_ch.sink), .rsp(rsp_ch.source)
	);

	// predictor state
	logic [9:0] p_base;
	logic [6:0] p_fcount;
	logic [4:0] p_tlb_used;
	logic [8:0] p_pcount;
	bit p_valid [N_PAGES];
	logic [9:0] p_frame [N_PAGES];
	logic [31:0] p_stamp [N_PAGES];
	bit t_valid [N_TLB];
	logic [7:0] t_page [N_TLB];
	logic [9:0] t_frame [N_TLB];
	int unsigned handed_out;
	logic [31:0] ref_idx;
	logic [15:0] fault_cnt;

	rsp_t pending_rsp[$];
	int errors;
	int mismatches;
	bit long_hold_req;
	longint cycles;

	typedef struct {
		logic [7:0] page;
		bit new_run;
		bit fixed;
		rsp_t want;
	} stim_row_t;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic void clear_tables();
		for (int i = 0; i < N_PAGES; i++) begin
			p_valid[i] = 0;
			p_frame[i] = '0;
			p_stamp[i] = '0;
		end
		for (int i = 0; i < N_TLB; i++) begin
			t_valid[i] = 0;
			t_page[i] = '0;
			t_frame[i] = '0;
		end
		handed_out = 0;
		ref_idx = '0;
		fault_cnt = '0;
	endfunction

	function automatic void tlb_fill(logic [7:0] pg, logic [9:0] fr);
		int lim;
		int cnt;
		int best;
		bit found;
		lim = p_tlb_used;
		cnt = 0;
		best = 0;
		found = 0;
		if (lim < 1) lim = 1;
		if (lim > N_TLB) lim = N_TLB;
		for (int i = 0; i < N_TLB; i++) cnt += t_valid[i];
		if (cnt < lim) begin
			for (int i = 0; i < N_TLB; i++) if (!t_valid[i]) begin
				best = i;
				break;
			end
		end else begin
			for (int i = 0; i < N_TLB; i++) begin
				if (!t_valid[i]) continue;
				if (!found || p_stamp[t_page[i]] < p_stamp[t_page[best]] ||
				    (p_stamp[t_page[i]] == p_stamp[t_page[best]] &&
				     t_page[i] < t_page[best])) begin
					best = i;
					found = 1;
				end
			end
		end
		t_valid[best] = 1;
		t_page[best] = pg;
		t_frame[best] = fr;
	endfunction

	function automatic rsp_t translate(req_t rq);
		rsp_t r;
		int frames;
		bit hit;
		bit found;
		int victim;
		logic [9:0] fr;
		r.status = ST_TLB_HIT;
		r.frame = '0;
		r.evicted_page = '0;
		fr = '0;
		hit = 0;
		found = 0;
		victim = 0;
		frames = (p_fcount > N_FRAMES) ? N_FRAMES : p_fcount;
		if (rq.new_run) clear_tables();
		if (rq.page >= p_pcount) r.status = ST_OUT_OF_RANGE;
		else if (frames == 0) r.status = ST_NO_FRAMES;
		else begin
			for (int i = 0; i < N_TLB; i++) if (t_valid[i] && t_page[i] == rq.page) begin
				hit = 1;
				fr = t_frame[i];
				break;
			end
			if (hit) r.status = ST_TLB_HIT;
			else if (p_valid[rq.page]) begin
				r.status = ST_TABLE_HIT;
				fr = p_frame[rq.page];
				tlb_fill(rq.page, fr);
			end else if (handed_out < frames) begin
				r.status = ST_FAULT_FREE;
				fr = 10'((p_base + handed_out) % N_PHYS);
				p_valid[rq.page] = 1;
				p_frame[rq.page] = fr;
				tlb_fill(rq.page, fr);
				handed_out++;
			end else begin
				for (int i = 0; i < N_PAGES; i++)
					if (p_valid[i] && (!found || p_stamp[i] < p_stamp[victim])) begin
						victim = i;
						found = 1;
					end
				if (!found) r.status = ST_NO_FRAMES;
				else begin
					r.status = ST_FAULT_EVICT;
					r.evicted_page = 8'(victim);
					fr = p_frame[victim];
					p_valid[victim] = 0;
					for (int i = 0; i < N_TLB; i++)
						if (t_valid[i] && t_page[i] == victim) t_valid[i] = 0;
					p_valid[rq.page] = 1;
					p_frame[rq.page] = fr;
					tlb_fill(rq.page, fr);
				end
			end
			if (r.status <= ST_FAULT_EVICT) begin
				p_stamp[rq.page] = ref_idx;
				ref_idx++;
				if (r.status >= ST_FAULT_FREE && fault_cnt != FAULT_MAX) fault_cnt++;
				r.frame = fr;
			end
		end
		r.fault_count = fault_cnt;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_BASE_FRAME: p_base = 10'(value);
			REG_FRAME_COUNT: p_fcount = 7'(value);
			REG_TLB_USED: p_tlb_used = 5'(value);
			default: p_pcount = 9'(value);
		endcase
	endtask

	task automatic configure(int base, int fcount, int tlbn, int pcount);
		write_reg(REG_BASE_FRAME, base);
		write_reg(REG_FRAME_COUNT, fcount);
		write_reg(REG_TLB_USED, tlbn);
		write_reg(REG_PAGE_COUNT, pcount);
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// valid stays high after an accepted request until the next gap or drain
	task automatic send_request(logic [7:0] pg, bit nr, bit fixed, rsp_t want);
		req_t rq;
		rsp_t pred;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		rq.page = pg;
		rq.new_run = nr;
		req_ch.valid <= 1;
		req_ch.data <= rq;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pred = translate(rq);
		if (fixed && pred != want) begin
			errors++;
			$display("table row disagrees with predictor: page %0d", pg);
		end
		pending_rsp = {pending_rsp, pred};
	endtask

	// result side: random stalls, plus an optional long hold-off
	initial begin
		int stall;
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				rsp_ch.ready <= 0;
				repeat (2000) @(posedge clk);
				long_hold_req = 0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				rsp_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %p", rsp_ch.data);
			end else begin
				rsp_t want;
				want = pending_rsp.pop_front();
				if (rsp_ch.data.status !== want.status || rsp_ch.data.frame !== want.frame ||
				    rsp_ch.data.evicted_page !== want.evicted_page ||
				    rsp_ch.data.fault_count !== want.fault_count) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %p got %p", want, rsp_ch.data);
				end
			end
		end
	end

	function automatic rsp_t mk(status_t s, int fr, int ev, int fc);
		rsp_t r;
		r.status = s;
		r.frame = 10'(fr);
		r.evicted_page = 8'(ev);
		r.fault_count = 16'(fc);
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		int phase_cfg[6][4];
		int hot;
		logic [7:0] pg;
		errors = 0;
		mismatches = 0;
		long_hold_req = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_BASE_FRAME;
		cfg_data = '0;
		req_ch.valid = 0;
		req_ch.data = '0;
		p_base = 0; p_fcount = 0; p_tlb_used = 16; p_pcount = 256;
		clear_tables();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset config: no frames
		rows = '{
			'{8'd0, 1'b0, 1'b1, mk(ST_NO_FRAMES, 0, 0, 0)},
			'{8'd255, 1'b1, 1'b1, mk(ST_NO_FRAMES, 0, 0, 0)}
		};
		foreach (rows[i]) send_request(rows[i].page, rows[i].new_run, rows[i].fixed, rows[i].want);
		drain();

		// two frames from top of physical range (second wraps to 0), TLB of 0 acts as 1, 4 pages
		configure(1023, 2, 0, 4);
		rows = '{
			'{8'd0, 1'b1, 1'b1, mk(ST_FAULT_FREE, 1023, 0, 1)},
			'{8'd0, 1'b0, 1'b1, mk(ST_TLB_HIT, 1023, 0, 1)},
			'{8'd1, 1'b0, 1'b1, mk(ST_FAULT_FREE, 0, 0, 2)},
			'{8'd0, 1'b0, 1'b1, mk(ST_TABLE_HIT, 1023, 0, 2)},
			'{8'd2, 1'b0, 1'b1, mk(ST_FAULT_EVICT, 0, 1, 3)},
			'{8'd4, 1'b0, 1'b1, mk(ST_OUT_OF_RANGE, 0, 0, 3)},
			'{8'd255, 1'b0, 1'b1, mk(ST_OUT_OF_RANGE, 0, 0, 3)},
			'{8'd3, 1'b0, 1'b0, mk(ST_TLB_HIT, 0, 0, 0)},
			'{8'd1, 1'b0, 1'b0, mk(ST_TLB_HIT, 0, 0, 0)},
			'{8'd3, 1'b1, 1'b1, mk(ST_FAULT_FREE, 1023, 0, 1)}
		};
		foreach (rows[i]) send_request(rows[i].page, rows[i].new_run, rows[i].fixed, rows[i].want);
		drain();

		// frame count lowered mid-run, frame count above limit, full page space
		configure(5, 1, 20, 256);
		rows = '{
			'{8'd7, 1'b0, 1'b0, mk(ST_TLB_HIT, 0, 0, 0)},
			'{8'd8, 1'b0, 1'b0, mk(ST_TLB_HIT, 0, 0, 0)}
		};
		foreach (rows[i]) send_request(rows[i].page, rows[i].new_run, rows[i].fixed, rows[i].want);
		drain();
		configure(0, 127, 16, 256);
		rows = '{
			'{8'd255, 1'b1, 1'b1, mk(ST_FAULT_FREE, 0, 0, 1)},
			'{8'd0, 1'b0, 1'b1, mk(ST_FAULT_FREE, 1, 0, 2)},
			'{8'd255, 1'b0, 1'b1, mk(ST_TLB_HIT, 0, 0, 2)}
		};
		foreach (rows[i]) send_request(rows[i].page, rows[i].new_run, rows[i].fixed, rows[i].want);
		drain();

		// random phases: mostly in-range working sets, some out of range and new runs
		phase_cfg = '{
			'{1000, 64, 16, 256},
			'{512, 8, 4, 40},
			'{1020, 16, 1, 256},
			'{3, 3, 16, 10},
			'{700, 100, 31, 1},
			'{0, 0, 8, 256}
		};
		for (int ph = 0; ph < 6; ph++) begin
			configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
			if (ph == 1) long_hold_req = 1;
			hot = (ph == 0) ? 100 : 24;
			for (int n = 0; n < 200; n++) begin
				case ($urandom_range(0, 9))
					0: pg = 8'($urandom);
					1, 2: pg = 8'($urandom_range(0, 255));
					default: pg = 8'($urandom_range(0, hot - 1));
				endcase
				if (phase_cfg[ph][3] < 256 && $urandom_range(0, 3) != 0)
					pg = 8'($urandom_range(0, phase_cfg[ph][3] - 1));
				send_request(pg, $urandom_range(0, 60) == 0, 0, '0);
			end
			// pause until every result is back
			drain();
		end

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tlbdp_pkg.sv
hdl/tlbdp_stream_if.sv
hdl/tlbdp_ram.sv
hdl/tlbdp_tlb.sv
hdl/tlb_lru_demand_paging.sv
tb/sv/tb_tlb_lru_demand_paging.sv
